[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the complex fixed-point ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

[sv/cfpa_pkg.sv]
// Package with the shared types and codes of the complex fixed-point ALU.
`timescale 1ns / 1ps
package cfpa_pkg;

    localparam int WORD_BITS_DEF     = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_EQ  = 3'd4;
    localparam logic [2:0] CMD_NE  = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic       valid;
        logic       is_div;
        logic       dz;
        logic       neg_re;
        logic       neg_im;
        logic       big_re;
        logic       big_im;
        logic       flag;
        logic [1:0] status;
    } ctrl_t;

endpackage

[sv/cfpa_front.sv]
// Front pipeline: operand register, products, sums, early results and divider setup.
`timescale 1ns / 1ps
module cfpa_front #(
    parameter int W = cfpa_pkg::WORD_BITS_DEF,
    parameter int F = cfpa_pkg::FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0]            in_cmd,
    input  logic signed [W-1:0]   in_ar,
    input  logic signed [W-1:0]   in_ai,
    input  logic signed [W-1:0]   in_br,
    input  logic signed [W-1:0]   in_bi,
    output cfpa_pkg::ctrl_t       out_ctrl,
    output logic [W-1:0]          out_re,
    output logic [W-1:0]          out_im,
    output logic [2*W-1:0]        out_den,
    output logic [2*W+F-1:0]      out_rem_re,
    output logic [2*W+F-1:0]      out_rem_im
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = SW + F;
    localparam int RW = 2 * W + F;
    localparam int CW = 3 * W + F + 2;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_add(input logic signed [W:0] s);
        logic ovf;
        ovf = s[W] ^ s[W-1];
        sat_add = ovf ? {1'b1, (s[W] ? MINV : MAXV)} : {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_mul(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] sh;
        logic ovf;
        sh  = v >>> F;
        ovf = !((&sh[SW-1:W-1]) || !(|sh[SW-1:W-1]));
        sat_mul = ovf ? {1'b1, (sh[SW-1] ? MINV : MAXV)} : {1'b0, sh[W-1:0]};
    endfunction

    // Stage 1: operands.
    logic                s1_valid_reg;
    logic [2:0]          s1_cmd_reg;
    logic signed [W-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // Stage 2: products and part sums.
    logic                 s2_valid_reg;
    logic [2:0]           s2_cmd_reg;
    logic                 s2_eq_reg;
    logic signed [PW-1:0] s2_rr_reg, s2_ii_reg, s2_ir_reg, s2_ri_reg, s2_kr_reg, s2_ki_reg;
    logic signed [W:0]    s2_sre_reg, s2_sim_reg;

    // Stage 3: combined cross products.
    logic                 s3_valid_reg;
    logic [2:0]           s3_cmd_reg;
    logic                 s3_eq_reg;
    logic signed [SW-1:0] s3_mre_reg, s3_mim_reg, s3_nre_reg, s3_nim_reg;
    logic [PW-1:0]        s3_k_reg;
    logic signed [W:0]    s3_sre_reg, s3_sim_reg;

    // Stage 4: registered outputs.
    cfpa_pkg::ctrl_t ctrl_reg, ctrl_next;
    logic [W-1:0]    re_reg, re_next, im_reg, im_next;
    logic [PW-1:0]   den_reg;
    logic [RW-1:0]   rem_re_reg, rem_re_next, rem_im_reg, rem_im_next;

    logic [W:0]           add_re, add_im, mul_re, mul_im;
    logic signed [NW-1:0] num_re, num_im;

    always_comb begin
        add_re = sat_add(s3_sre_reg);
        add_im = sat_add(s3_sim_reg);
        mul_re = sat_mul(s3_mre_reg);
        mul_im = sat_mul(s3_mim_reg);
        num_re = NW'(s3_nre_reg) <<< F;
        num_im = NW'(s3_nim_reg) <<< F;
        rem_re_next = num_re[NW-1] ? RW'(-num_re) : RW'(num_re);
        rem_im_next = num_im[NW-1] ? RW'(-num_im) : RW'(num_im);
        ctrl_next        = '0;
        ctrl_next.valid  = s3_valid_reg;
        ctrl_next.neg_re = num_re[NW-1];
        ctrl_next.neg_im = num_im[NW-1];
        ctrl_next.big_re = CW'(rem_re_next) >= (CW'(s3_k_reg) << (W + 1));
        ctrl_next.big_im = CW'(rem_im_next) >= (CW'(s3_k_reg) << (W + 1));
        re_next = '0;
        im_next = '0;
        unique case (s3_cmd_reg)
            cfpa_pkg::CMD_ADD, cfpa_pkg::CMD_SUB: begin
                re_next = add_re[W-1:0];
                im_next = add_im[W-1:0];
                ctrl_next.status = (add_re[W] || add_im[W]) ? cfpa_pkg::ST_OVF
                                                            : cfpa_pkg::ST_OK;
            end
            cfpa_pkg::CMD_MUL: begin
                re_next = mul_re[W-1:0];
                im_next = mul_im[W-1:0];
                ctrl_next.status = (mul_re[W] || mul_im[W]) ? cfpa_pkg::ST_OVF
                                                            : cfpa_pkg::ST_OK;
            end
            cfpa_pkg::CMD_DIV: begin
                ctrl_next.is_div = 1'b1;
                ctrl_next.dz     = (s3_k_reg == '0);
                ctrl_next.status = (s3_k_reg == '0) ? cfpa_pkg::ST_DZ : cfpa_pkg::ST_OK;
            end
            cfpa_pkg::CMD_EQ: ctrl_next.flag = s3_eq_reg;
            cfpa_pkg::CMD_NE: ctrl_next.flag = !s3_eq_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            ctrl_reg     <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_cmd_reg <= in_cmd;
            s1_ar_reg  <= in_ar;
            s1_ai_reg  <= in_ai;
            s1_br_reg  <= in_br;
            s1_bi_reg  <= in_bi;

            s2_cmd_reg <= s1_cmd_reg;
            s2_eq_reg  <= (s1_ar_reg == s1_br_reg) && (s1_ai_reg == s1_bi_reg);
            s2_rr_reg  <= s1_ar_reg * s1_br_reg;
            s2_ii_reg  <= s1_ai_reg * s1_bi_reg;
            s2_ir_reg  <= s1_ai_reg * s1_br_reg;
            s2_ri_reg  <= s1_ar_reg * s1_bi_reg;
            s2_kr_reg  <= s1_br_reg * s1_br_reg;
            s2_ki_reg  <= s1_bi_reg * s1_bi_reg;
            if (s1_cmd_reg == cfpa_pkg::CMD_SUB) begin
                s2_sre_reg <= (W+1)'(s1_ar_reg) - (W+1)'(s1_br_reg);
                s2_sim_reg <= (W+1)'(s1_ai_reg) - (W+1)'(s1_bi_reg);
            end else begin
                s2_sre_reg <= (W+1)'(s1_ar_reg) + (W+1)'(s1_br_reg);
                s2_sim_reg <= (W+1)'(s1_ai_reg) + (W+1)'(s1_bi_reg);
            end

            s3_cmd_reg <= s2_cmd_reg;
            s3_eq_reg  <= s2_eq_reg;
            s3_sre_reg <= s2_sre_reg;
            s3_sim_reg <= s2_sim_reg;
            s3_mre_reg <= SW'(s2_rr_reg) - SW'(s2_ii_reg);
            s3_mim_reg <= SW'(s2_ir_reg) + SW'(s2_ri_reg);
            s3_nre_reg <= SW'(s2_rr_reg) + SW'(s2_ii_reg);
            s3_nim_reg <= SW'(s2_ir_reg) - SW'(s2_ri_reg);
            s3_k_reg   <= PW'(s2_kr_reg) + PW'(s2_ki_reg);

            re_reg     <= re_next;
            im_reg     <= im_next;
            den_reg    <= s3_k_reg;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
        end
    end

    assign out_ctrl   = ctrl_reg;
    assign out_re     = re_reg;
    assign out_im     = im_reg;
    assign out_den    = den_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;

endmodule

[sv/cfpa_div_cell.sv]
// One restoring division cell that settles one quotient bit of both parts.
`timescale 1ns / 1ps
module cfpa_div_cell #(
    parameter int W     = cfpa_pkg::WORD_BITS_DEF,
    parameter int F     = cfpa_pkg::FRACTION_BITS_DEF,
    parameter int SHIFT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  cfpa_pkg::ctrl_t   in_ctrl,
    input  logic [W-1:0]      in_re,
    input  logic [W-1:0]      in_im,
    input  logic [2*W-1:0]    in_den,
    input  logic [2*W+F-1:0]  in_rem_re,
    input  logic [2*W+F-1:0]  in_rem_im,
    input  logic [W:0]        in_q_re,
    input  logic [W:0]        in_q_im,
    output cfpa_pkg::ctrl_t   out_ctrl,
    output logic [W-1:0]      out_re,
    output logic [W-1:0]      out_im,
    output logic [2*W-1:0]    out_den,
    output logic [2*W+F-1:0]  out_rem_re,
    output logic [2*W+F-1:0]  out_rem_im,
    output logic [W:0]        out_q_re,
    output logic [W:0]        out_q_im
);

    localparam int RW = 2 * W + F;
    localparam int CW = 3 * W + F + 2;

    cfpa_pkg::ctrl_t ctrl_reg;
    logic [W-1:0]    re_reg, im_reg;
    logic [2*W-1:0]  den_reg;
    logic [RW-1:0]   rem_re_reg, rem_im_reg;
    logic [W:0]      q_re_reg, q_im_reg;

    logic [CW-1:0] den_sh, diff_re, diff_im;
    logic          ge_re, ge_im;

    always_comb begin
        den_sh  = CW'(in_den) << SHIFT;
        diff_re = CW'(in_rem_re) - den_sh;
        diff_im = CW'(in_rem_im) - den_sh;
        ge_re   = CW'(in_rem_re) >= den_sh;
        ge_im   = CW'(in_rem_im) >= den_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg     <= in_re;
            im_reg     <= in_im;
            den_reg    <= in_den;
            rem_re_reg <= ge_re ? diff_re[RW-1:0] : in_rem_re;
            rem_im_reg <= ge_im ? diff_im[RW-1:0] : in_rem_im;
            q_re_reg   <= {in_q_re[W-1:0], ge_re};
            q_im_reg   <= {in_q_im[W-1:0], ge_im};
        end
    end

    assign out_ctrl   = ctrl_reg;
    assign out_re     = re_reg;
    assign out_im     = im_reg;
    assign out_den    = den_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;

endmodule

[sv/cfpa_back.sv]
// Output stage: signs and saturates quotients and holds the result register.
`timescale 1ns / 1ps
module cfpa_back #(
    parameter int W = cfpa_pkg::WORD_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  cfpa_pkg::ctrl_t  in_ctrl,
    input  logic [W-1:0]     in_re,
    input  logic [W-1:0]     in_im,
    input  logic [W:0]       in_q_re,
    input  logic [W:0]       in_q_im,
    output logic             out_valid,
    output logic [W-1:0]     out_re,
    output logic [W-1:0]     out_im,
    output logic             out_flag,
    output logic [1:0]       out_status
);

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_q(input logic [W:0] q, input logic neg,
                                         input logic big);
        logic ovf;
        logic [W-1:0] mag;
        mag = q[W-1:0];
        if (neg) begin
            ovf   = big || q[W] || (q[W-1] && (|q[W-2:0]));
            sat_q = ovf ? {1'b1, MINV} : {1'b0, W'(-mag)};
        end else begin
            ovf   = big || q[W] || q[W-1];
            sat_q = ovf ? {1'b1, MAXV} : {1'b0, mag};
        end
    endfunction

    logic           valid_reg;
    logic [W-1:0]   re_reg, re_next, im_reg, im_next;
    logic           flag_reg;
    logic [1:0]     status_reg, status_next;
    logic [W:0]     d_re, d_im;

    always_comb begin
        d_re        = sat_q(in_q_re, in_ctrl.neg_re, in_ctrl.big_re);
        d_im        = sat_q(in_q_im, in_ctrl.neg_im, in_ctrl.big_im);
        re_next     = in_re;
        im_next     = in_im;
        status_next = in_ctrl.status;
        if (in_ctrl.is_div && !in_ctrl.dz) begin
            re_next     = d_re[W-1:0];
            im_next     = d_im[W-1:0];
            status_next = (d_re[W] || d_im[W]) ? cfpa_pkg::ST_OVF : cfpa_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg     <= re_next;
            im_reg     <= im_next;
            flag_reg   <= in_ctrl.flag;
            status_reg <= status_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_re     = re_reg;
    assign out_im     = im_reg;
    assign out_flag   = flag_reg;
    assign out_status = status_reg;

endmodule

[sv/complex_fixed_point_alu.sv]
// Top level of the complex fixed-point ALU: front pipeline, divider cell chain, output stage.
// Every command takes the same path through the pipeline.
// Throughput is one request per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stalled result stalls the whole chain.
// The divider is a chain of WORD_BITS + 1 cells, one quotient bit per cell.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module complex_fixed_point_alu #(
    parameter int WORD_BITS     = cfpa_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = cfpa_pkg::FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // left_re, left_im, right_re, right_im from the lowest bit up.
    input  logic [((4 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // command.
    input  logic [2:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_re, out_im from the lowest bit up.
    output logic [((2 * WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // compare_flag, status from the lowest bit up.
    output logic [2:0]              m_tuser
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int ODW = ((2 * W + 7) / 8) * 8;
    localparam int NC  = W + 1;
    localparam int RW  = 2 * W + F;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cfpa_pkg::ctrl_t  c_ctrl [NC+1];
    logic [W-1:0]     c_re   [NC+1];
    logic [W-1:0]     c_im   [NC+1];
    logic [2*W-1:0]   c_den  [NC+1];
    logic [RW-1:0]    c_rre  [NC+1];
    logic [RW-1:0]    c_rim  [NC+1];
    logic [W:0]       c_qre  [NC+1];
    logic [W:0]       c_qim  [NC+1];

    cfpa_front #(.W(W), .F(F)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_cmd     (s_tuser),
        .in_ar      (s_tdata[W-1:0]),
        .in_ai      (s_tdata[2*W-1:W]),
        .in_br      (s_tdata[3*W-1:2*W]),
        .in_bi      (s_tdata[4*W-1:3*W]),
        .out_ctrl   (c_ctrl[0]),
        .out_re     (c_re[0]),
        .out_im     (c_im[0]),
        .out_den    (c_den[0]),
        .out_rem_re (c_rre[0]),
        .out_rem_im (c_rim[0])
    );

    assign c_qre[0] = '0;
    assign c_qim[0] = '0;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        cfpa_div_cell #(.W(W), .F(F), .SHIFT(W - i)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .in_ctrl    (c_ctrl[i]),
            .in_re      (c_re[i]),
            .in_im      (c_im[i]),
            .in_den     (c_den[i]),
            .in_rem_re  (c_rre[i]),
            .in_rem_im  (c_rim[i]),
            .in_q_re    (c_qre[i]),
            .in_q_im    (c_qim[i]),
            .out_ctrl   (c_ctrl[i+1]),
            .out_re     (c_re[i+1]),
            .out_im     (c_im[i+1]),
            .out_den    (c_den[i+1]),
            .out_rem_re (c_rre[i+1]),
            .out_rem_im (c_rim[i+1]),
            .out_q_re   (c_qre[i+1]),
            .out_q_im   (c_qim[i+1])
        );
    end

    logic [W-1:0] res_re, res_im;
    logic         res_flag;
    logic [1:0]   res_status;

    cfpa_back #(.W(W)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_ctrl    (c_ctrl[NC]),
        .in_re      (c_re[NC]),
        .in_im      (c_im[NC]),
        .in_q_re    (c_qre[NC]),
        .in_q_im    (c_qim[NC]),
        .out_valid  (m_tvalid),
        .out_re     (res_re),
        .out_im     (res_im),
        .out_flag   (res_flag),
        .out_status (res_status)
    );

    assign m_tdata = ODW'({res_im, res_re});
    assign m_tuser = {res_status, res_flag};

    `ASSERT_PROP(a_status_code, aclk, aresetn,
        m_tvalid |-> (res_status == cfpa_pkg::ST_OK || res_status == cfpa_pkg::ST_DZ ||
                      res_status == cfpa_pkg::ST_OVF), "bad status")
    `ASSERT_PROP(a_dz_zero, aclk, aresetn,
        (m_tvalid && res_status == cfpa_pkg::ST_DZ) |-> (res_re == '0 && res_im == '0),
        "divide by zero with nonzero parts")
    `ASSERT_PROP(a_flag_zero, aclk, aresetn,
        (m_tvalid && res_flag) |->
            (res_re == '0 && res_im == '0 && res_status == cfpa_pkg::ST_OK),
        "compare result with nonzero parts")
    `ASSERT_PROP(a_ready_follows, aclk, aresetn, (m_tvalid && !m_tready) |-> !s_tready,
        "request accepted while output stalled")

endmodule
